// ----- hw/rtl/tcw_pkg.sv -----
`default_nettype none

package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int LAST_ROW   = (ROWS - 1) * COLUMNS;
   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;

   typedef logic [ADDR_W-1:0] addr_type;
   typedef logic [15:0]       cell_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [ROW_W-1:0]  row_type;

   localparam logic OP_PUT  = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [7:0] CH_NEWLINE = 8'd10;
   localparam logic [7:0] CH_TAB     = 8'd9;

   localparam cell_type BLANK_CELL = 16'h0720;
   localparam cell_type BARE_SPACE = 16'h0020;

   localparam logic [7:0] ATTR_TABLE [8] = '{
      8'h0F, 8'h07, 8'h0E, 8'h0C, 8'h09, 8'h0A, 8'h0F, 8'h0F
   };

   function automatic cell_type char_cell(input logic [2:0] color, input logic [7:0] ch);
      char_cell = {ATTR_TABLE[color], ch};
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tcw_screen_ram.sv -----
`default_nettype none

module tcw_screen_ram (
   input  wire               clock,
   input  wire               wr_en,
   input  tcw_pkg::addr_type wr_addr,
   input  tcw_pkg::cell_type wr_data,
   input  wire               rd_en,
   input  tcw_pkg::addr_type rd_addr,
   output tcw_pkg::cell_type rd_data
);
   import tcw_pkg::*;

   cell_type mem [CELL_COUNT];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/text_console_writer.sv -----
// Text console writer.
// Input channel req_*: op 0 puts a character (newline, tab or printable) at
// the cursor with the given color; op 1 reads one screen cell by index.
// Result channel rsp_*: one item per input item, carrying the accepted flag,
// read data, cursor after the item and the scroll flag.
// csr_wr_en/csr_wr_data write the enable bit; a disabled console rejects puts.
// Each item is accepted in IDLE, runs in EXEC (read issued or put done) and
// is loaded into the output register in DONE; the next item is accepted
// only once the block is back in IDLE. A put that scrolls also passes SCROLL
// and PUT_WR: the single write port of the screen store copies every row up
// one cell a cycle, each source cell registered by the read port first.
// After reset the block clears the screen store to blank cells, one cell a
// cycle, with req_stall high; csr writes are taken meanwhile. Cursor resets
// to the top left, enable resets to 1.
// A stalled result is held in the output register; the engine finishes the
// next item and waits with it until the output register frees.
`default_nettype none

module text_console_writer (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire                 req_op,
   input  wire  [7:0]          req_char_code,
   input  wire  [2:0]          req_color,
   input  wire  [10:0]         req_cell_index,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic                rsp_accepted,
   output tcw_pkg::cell_type   rsp_cell_data,
   output tcw_pkg::row_type    rsp_cursor_row,
   output tcw_pkg::col_type    rsp_cursor_col,
   output logic                rsp_scrolled,
   input  wire                 csr_wr_en,
   input  wire                 csr_wr_data
);
   import tcw_pkg::*;

   typedef enum logic [2:0] {CLEAR, IDLE, EXEC, SCROLL, PUT_WR, DONE} state_type;

   state_type state_ff, state_in;
   addr_type  sweep_ff, sweep_in;
   logic      enable_ff, enable_in;
   col_type   x_ff, x_in;
   row_type   y_ff, y_in;

   logic        op_ff, op_in;
   logic [7:0]  ch_ff, ch_in;
   logic [2:0]  color_ff, color_in;
   logic [10:0] idx_ff, idx_in;
   logic        acc_ff, acc_in;
   logic        inrange_ff, inrange_in;
   logic        scr_ff, scr_in;

   logic     wr_en_ff, wr_en_in;
   addr_type wr_addr_ff, wr_addr_in;
   logic     wr_copy_ff, wr_copy_in;
   cell_type wr_data_ff, wr_data_in;

   logic     rsp_valid_ff, rsp_valid_in;
   logic     rsp_acc_ff, rsp_acc_in;
   cell_type rsp_data_ff, rsp_data_in;
   row_type  rsp_row_ff, rsp_row_in;
   col_type  rsp_col_ff, rsp_col_in;
   logic     rsp_scr_ff, rsp_scr_in;

   logic     rd_en;
   addr_type rd_addr;
   cell_type rd_data;

   col_type    x1;
   row_type    y1;
   logic [7:0] tab_sum;

   tcw_screen_ram u_ram (
      .clock   (clock),
      .wr_en   (wr_en_ff),
      .wr_addr (wr_addr_ff),
      .wr_data (wr_copy_ff ? rd_data : wr_data_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      enable_in    = csr_wr_en ? csr_wr_data : enable_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      op_in        = op_ff;
      ch_in        = ch_ff;
      color_in     = color_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      inrange_in   = inrange_ff;
      scr_in       = scr_ff;
      wr_en_in     = 1'b0;
      wr_addr_in   = wr_addr_ff;
      wr_copy_in   = 1'b0;
      wr_data_in   = wr_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_acc_in   = rsp_acc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_scr_in   = rsp_scr_ff;
      rd_en        = 1'b0;
      rd_addr      = sweep_ff;

      // wrap a printable character at the row end
      x1 = x_ff;
      y1 = y_ff;
      if (x_ff >= COL_W'(COLUMNS)) begin
         x1 = '0;
         if (y_ff < ROW_W'(ROWS)) begin
            y1 = y_ff + 1'b1;
         end
      end
      tab_sum = {1'b0, x_ff} + 8'd4;

      unique case (state_ff)
         CLEAR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = sweep_ff;
            wr_data_in = BLANK_CELL;
            if (sweep_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = IDLE;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         IDLE: begin
            if (req_valid) begin
               op_in    = req_op;
               ch_in    = req_char_code;
               color_in = req_color;
               idx_in   = req_cell_index;
               state_in = EXEC;
            end
         end
         EXEC: begin
            acc_in     = 1'b0;
            scr_in     = 1'b0;
            inrange_in = 1'b0;
            state_in   = DONE;
            if (op_ff == OP_READ) begin
               inrange_in = (idx_ff < 11'(CELL_COUNT));
               rd_en      = (idx_ff < 11'(CELL_COUNT));
               rd_addr    = ADDR_W'(idx_ff);
            end else if (enable_ff) begin
               acc_in = 1'b1;
               if (ch_ff == CH_NEWLINE) begin
                  if (y_ff < ROW_W'(ROWS)) begin
                     y_in = y_ff + 1'b1;
                  end
                  x_in = '0;
               end else if (ch_ff == CH_TAB) begin
                  x_in = (tab_sum > 8'(COLUMNS)) ? COL_W'(COLUMNS) : tab_sum[COL_W-1:0];
               end else if (y1 >= ROW_W'(ROWS)) begin
                  y_in     = ROW_W'(ROWS - 1);
                  x_in     = x1;
                  scr_in   = 1'b1;
                  sweep_in = '0;
                  state_in = SCROLL;
               end else begin
                  y_in       = y1;
                  x_in       = x1 + 1'b1;
                  wr_en_in   = 1'b1;
                  wr_addr_in = ADDR_W'(y1 * COLUMNS) + ADDR_W'(x1);
                  wr_data_in = char_cell(color_ff, ch_ff);
               end
            end
         end
         SCROLL: begin
            wr_en_in   = 1'b1;
            wr_addr_in = sweep_ff;
            if (sweep_ff < ADDR_W'(LAST_ROW)) begin
               rd_en      = 1'b1;
               rd_addr    = sweep_ff + ADDR_W'(COLUMNS);
               wr_copy_in = 1'b1;
            end else begin
               wr_data_in = BARE_SPACE;
            end
            if (sweep_ff == ADDR_W'(CELL_COUNT - 1)) begin
               state_in = PUT_WR;
            end else begin
               sweep_in = sweep_ff + 1'b1;
            end
         end
         PUT_WR: begin
            wr_en_in   = 1'b1;
            wr_addr_in = ADDR_W'(LAST_ROW) + ADDR_W'(x_ff);
            wr_data_in = char_cell(color_ff, ch_ff);
            x_in       = x_ff + 1'b1;
            state_in   = DONE;
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_data_in  = inrange_ff ? rd_data : '0;
               rsp_row_in   = y_ff;
               rsp_col_in   = x_ff;
               rsp_scr_in   = scr_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CLEAR;
         sweep_ff     <= '0;
         enable_ff    <= 1'b1;
         x_ff         <= '0;
         y_ff         <= '0;
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         enable_ff    <= enable_in;
         x_ff         <= x_in;
         y_ff         <= y_in;
         wr_en_ff     <= wr_en_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff       <= op_in;
      ch_ff       <= ch_in;
      color_ff    <= color_in;
      idx_ff      <= idx_in;
      acc_ff      <= acc_in;
      inrange_ff  <= inrange_in;
      scr_ff      <= scr_in;
      wr_addr_ff  <= wr_addr_in;
      wr_copy_ff  <= wr_copy_in;
      wr_data_ff  <= wr_data_in;
      rsp_acc_ff  <= rsp_acc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_row_ff  <= rsp_row_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_scr_ff  <= rsp_scr_in;
   end

   assign req_stall      = (state_ff != IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_cell_data  = rsp_data_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/tcw_checker.sv -----
`default_nettype none

module tcw_checker (
   input wire               clock,
   input wire               reset,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input wire               rsp_accepted,
   input tcw_pkg::cell_type rsp_cell_data,
   input tcw_pkg::row_type  rsp_cursor_row,
   input tcw_pkg::col_type  rsp_cursor_col,
   input wire               rsp_scrolled
);
   import tcw_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_cell_data)
         && $stable(rsp_cursor_row) && $stable(rsp_cursor_col))
      else $error("stalled item changed");

   a_put_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_cell_data == '0)
      else $error("put item carries cell data");

   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_accepted && rsp_cursor_row == ROW_W'(ROWS - 1))
      else $error("scroll without put on last row");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cursor_row <= ROW_W'(ROWS) && rsp_cursor_col <= COL_W'(COLUMNS))
      else $error("cursor out of range");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_accepted   (rsp_accepted),
   .rsp_cell_data  (rsp_cell_data),
   .rsp_cursor_row (rsp_cursor_row),
   .rsp_cursor_col (rsp_cursor_col),
   .rsp_scrolled   (rsp_scrolled)
);

`default_nettype wire
